// ===== rtl/fredkin_cell_automaton_engine_macros.svh =====
// Assertion macros used by the checker file of the cell automaton engine.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FREDKIN_CELL_AUTOMATON_ENGINE_MACROS_SVH
`define FREDKIN_CELL_AUTOMATON_ENGINE_MACROS_SVH

// Property checked at every rising edge while reset is low.
`define FCE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define FCE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fce_pkg.sv =====
// Shared types and constants of the cell automaton engine.
// No dependencies; used by the top level, the checker and the testbench.
package fce_pkg;

  localparam int CFG_W     = 7;
  localparam int ROW_IN_W  = 6;
  localparam int COL_IN_W  = 6;
  localparam int AGE_OUT_W = 8;
  localparam int POP_W     = 13;
  localparam int IDX_W     = 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'd1;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_GEN   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
  } in_t;

  typedef struct packed {
    logic                 alive;
    logic [AGE_OUT_W-1:0] age;
    logic [POP_W-1:0]     population;
  } out_t;

endpackage

// ===== rtl/fce_cell_ram.sv =====
// Simple dual-port cell RAM: one write port, one read port, registered read.
// No dependencies; instantiated by the engine top level.
module fce_cell_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int WW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [WW-1:0] rd_data
);

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/fredkin_cell_automaton_engine.sv =====
// Top level of the cell automaton engine: control sequencer, row buffer, counters.
// Depends on fce_pkg and fce_cell_ram.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (fce_pkg::in_t)
//   out      output     out_valid / out_ready  out_data (fce_pkg::out_t)
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// A set or read transaction runs from the accepting cycle through the RAM
// read, the update and the result slot before the next acceptance.
// A generation walks the active grid in raster order through the single
// read port of the cell RAM: a self read opens each row, then each cell
// takes a right read, a down read and an update.
// A clear, and the pass that follows reset, write every RAM entry once
// (MAX_ROWS * MAX_COLS entries, 4096 by default) while in_ready is low.
// A waiting result sits in the output register; the next transaction is taken
// meanwhile and only its own finish waits for the output register to free up.
module fredkin_cell_automaton_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int AGE_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fce_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fce_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [fce_pkg::IDX_W-1:0] cfg_index,
  input  logic [fce_pkg::CFG_W-1:0] cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = ($clog2(MAX_ROWS + 1) > fce_pkg::CFG_W) ?
                         $clog2(MAX_ROWS + 1) : fce_pkg::CFG_W;
  localparam int CCW   = ($clog2(MAX_COLS + 1) > fce_pkg::CFG_W) ?
                         $clog2(MAX_COLS + 1) : fce_pkg::CFG_W;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int WW    = AGE_BITS + 1;

  localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;
  localparam logic [AW-1:0]       COLS_STEP = AW'(MAX_COLS);
  localparam logic [AW-1:0]       LAST_ADDR = AW'(CELLS - 1);
  localparam logic [RCW-1:0]      ROWS_CAP  = RCW'(MAX_ROWS);
  localparam logic [CCW-1:0]      COLS_CAP  = CCW'(MAX_COLS);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CELL_RD,
    S_CELL_OP,
    S_GSELF,
    S_GRIGHT,
    S_GDOWN,
    S_GCALC,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers and their clamped values.
  logic [fce_pkg::CFG_W-1:0] grid_rows, grid_cols;
  logic [RCW-1:0] rows_ext, eff_rows;
  logic [CCW-1:0] cols_ext, eff_cols;

  // Latched transaction.
  fce_pkg::kind_t op;
  logic [AW-1:0]  cell_addr;
  logic           op_inside;
  logic           clr_reply;
  logic [AW-1:0]  clr_addr;

  // Generation walk.
  logic [RCW-1:0]      gr;
  logic [CCW-1:0]      gc;
  logic [AW-1:0]       row_base;
  logic                cur_alive, right_alive, left_alive;
  logic [AGE_BITS-1:0] cur_age, right_age;
  logic                rowbuf [MAX_COLS];
  logic                up_q;

  // Result and live count.
  logic                res_alive;
  logic [AGE_BITS-1:0] res_age;
  logic [CNT_W-1:0]    pop;

  // RAM ports.
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [WW-1:0] wr_data, rd_data;
  logic          rd_alive;
  logic [AGE_BITS-1:0] rd_age;

  logic [AW-1:0] self_addr;
  logic          right_ok, down_ok, up_ok, last_col, last_row;
  logic [2:0]    nb;
  logic          new_alive;
  logic [AGE_BITS-1:0] new_age;
  logic          in_inside;

  logic [AGE_BITS+fce_pkg::AGE_OUT_W-1:0] age_wide;
  logic [CNT_W+fce_pkg::POP_W-1:0]        pop_wide;

  fce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .WW    (WW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_alive = rd_data[AGE_BITS];
  assign rd_age   = rd_data[AGE_BITS-1:0];

  // A register value of zero acts as one; values above the maximum are capped.
  assign rows_ext = RCW'(grid_rows);
  assign cols_ext = CCW'(grid_cols);
  assign eff_rows = (rows_ext == '0) ? RCW'(1) : (rows_ext > ROWS_CAP) ? ROWS_CAP : rows_ext;
  assign eff_cols = (cols_ext == '0) ? CCW'(1) : (cols_ext > COLS_CAP) ? COLS_CAP : cols_ext;

  assign in_inside = (RCW'(in_data.row) < eff_rows) && (CCW'(in_data.col) < eff_cols);
  assign in_ready  = (state == S_IDLE);

  // Neighbors outside the active grid count as dead.
  assign self_addr = row_base + AW'(gc);
  assign right_ok  = (gc + CCW'(1)) < eff_cols;
  assign down_ok   = (gr + RCW'(1)) < eff_rows;
  assign up_ok     = (gr != '0);
  assign last_col  = !right_ok;
  assign last_row  = !down_ok;

  // The right neighbor of the current cell and the cell below have not been
  // rewritten yet, so they come straight from the RAM. The cell above was
  // rewritten one row ago; its old flag lives in the row buffer. The left
  // neighbor's old flag is carried in a register.
  assign nb = 3'(up_ok & up_q) + 3'(left_alive) + 3'(right_ok & right_alive)
            + 3'(down_ok & rd_alive);
  assign new_alive = nb[0];
  assign new_age   = (nb[0] && cur_alive && (cur_age != AGE_MAX)) ?
                     cur_age + AGE_BITS'(1) : cur_age;

  always_comb begin
    case (state)
      S_CELL_RD: rd_addr = cell_addr;
      S_GRIGHT:  rd_addr = right_ok ? self_addr + AW'(1) : self_addr;
      S_GDOWN:   rd_addr = down_ok ? self_addr + COLS_STEP : self_addr;
      default:   rd_addr = self_addr;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = self_addr;
    wr_data = {new_alive, new_age};
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_CELL_OP: begin
        wr_en   = (op == fce_pkg::KIND_SET) && op_inside && !rd_alive;
        wr_addr = cell_addr;
        wr_data = {1'b1, rd_age};
      end
      S_GCALC: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign age_wide = {fce_pkg::AGE_OUT_W'(0), res_age};
  assign pop_wide = {fce_pkg::POP_W'(0), pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      out_valid  <= 1'b0;
      pop        <= '0;
      grid_rows  <= fce_pkg::CFG_RESET;
      grid_cols  <= fce_pkg::CFG_RESET;
      left_alive <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == fce_pkg::REG_GRID_ROWS) begin
          grid_rows <= cfg_data;
        end else if (cfg_index == fce_pkg::REG_GRID_COLS) begin
          grid_cols <= cfg_data;
        end
      end

      // The result slot reloads the output register itself.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            pop      <= '0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op        <= in_data.kind;
            cell_addr <= AW'(int'(in_data.row) * MAX_COLS + int'(in_data.col));
            op_inside <= in_inside;
            res_alive <= 1'b0;
            res_age   <= '0;
            case (in_data.kind)
              fce_pkg::KIND_GEN: begin
                gr         <= '0;
                gc         <= '0;
                row_base   <= '0;
                left_alive <= 1'b0;
                state      <= S_GSELF;
              end
              fce_pkg::KIND_CLEAR: begin
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: begin
                state <= S_CELL_RD;
              end
            endcase
          end
        end
        S_CELL_RD: begin
          state <= S_CELL_OP;
        end
        S_CELL_OP: begin
          if (op == fce_pkg::KIND_SET && op_inside && !rd_alive) begin
            pop <= pop + CNT_W'(1);
          end
          if (op == fce_pkg::KIND_READ && op_inside) begin
            res_alive <= rd_alive;
            res_age   <= rd_age;
          end
          state <= S_DONE;
        end
        S_GSELF: begin
          state <= S_GRIGHT;
        end
        S_GRIGHT: begin
          // At the start of a row the current cell comes from the read just issued.
          if (gc == '0) begin
            cur_alive <= rd_alive;
            cur_age   <= rd_age;
          end
          state <= S_GDOWN;
        end
        S_GDOWN: begin
          right_alive <= rd_alive;
          right_age   <= rd_age;
          up_q        <= rowbuf[gc[COL_W-1:0]];
          state       <= S_GCALC;
        end
        S_GCALC: begin
          rowbuf[gc[COL_W-1:0]] <= cur_alive;
          if (new_alive && !cur_alive) begin
            pop <= pop + CNT_W'(1);
          end else if (!new_alive && cur_alive) begin
            pop <= pop - CNT_W'(1);
          end
          if (!last_col) begin
            gc         <= gc + CCW'(1);
            left_alive <= cur_alive;
            cur_alive  <= right_alive;
            cur_age    <= right_age;
            state      <= S_GRIGHT;
          end else if (!last_row) begin
            gr         <= gr + RCW'(1);
            gc         <= '0;
            row_base   <= row_base + COLS_STEP;
            left_alive <= 1'b0;
            state      <= S_GSELF;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.alive      <= res_alive;
            out_data.age        <= age_wide[fce_pkg::AGE_OUT_W-1:0];
            out_data.population <= pop_wide[fce_pkg::POP_W-1:0];
            clr_reply           <= 1'b0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/fce_checker.sv =====
// Port-level checker for the cell automaton engine, bound to the top level.
// Depends on fce_pkg and fredkin_cell_automaton_engine_macros.svh.
`include "fredkin_cell_automaton_engine_macros.svh"

module fce_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input fce_pkg::in_t              in_data,
  input logic                      out_valid,
  input logic                      out_ready,
  input fce_pkg::out_t             out_data,
  input logic                      cfg_wr_en,
  input logic [fce_pkg::IDX_W-1:0] cfg_index,
  input logic [fce_pkg::CFG_W-1:0] cfg_data
);

  // A stalled result keeps its value.
  `FCE_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Every transaction leaves the idle state, so ready drops right after an accept.
  `FCE_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "accepted back to back")

  // The clearing pass after reset keeps the input closed.
  `FCE_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !in_ready, "input open right after reset")

  // No result appears in the cycle right after an accept.
  `FCE_ASSERT(a_no_instant_result, clk, rst, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")

endmodule

bind fredkin_cell_automaton_engine fce_checker u_fce_checker (.*);

// ===== tb/sv/fredkin_cell_automaton_engine_test.sv =====
// Self-checking testbench of the cell automaton engine: directed and random transactions.
// Depends on fce_pkg and the RTL top level fredkin_cell_automaton_engine.
`timescale 1ns / 1ps

module fredkin_cell_automaton_engine_test;

  localparam int GRID_MAX = 64;
  localparam int AGE_SAT  = 255;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fce_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fce_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [fce_pkg::IDX_W-1:0] cfg_index = '0;
  logic [fce_pkg::CFG_W-1:0] cfg_data = '0;

  fredkin_cell_automaton_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the engine's state. The grid is held at full size; the
  // active area only limits which cells take part in a generation.
  bit       live_mirror [GRID_MAX][GRID_MAX];
  int       age_mirror  [GRID_MAX][GRID_MAX];
  int       live_count;
  bit [6:0] rows_reg, cols_reg;

  fce_pkg::out_t expected_q[$];
  int   error_count;
  longint cycle_count;
  int   hold_off_cycles;   // receiver stalls while this is nonzero

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > GRID_MAX) return GRID_MAX;
    return rows_reg;
  endfunction

  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > GRID_MAX) return GRID_MAX;
    return cols_reg;
  endfunction

  // Advance the mirror by one transaction and return the result it must produce.
  function automatic fce_pkg::out_t predict_transaction(fce_pkg::in_t t);
    fce_pkg::out_t r;
    int nr, nc, n;
    int nbr [GRID_MAX][GRID_MAX];
    bit in_area;
    nr = active_rows();
    nc = active_cols();
    in_area = (t.row < nr) && (t.col < nc);
    r = '0;
    case (t.kind)
      fce_pkg::KIND_SET: begin
        if (in_area && !live_mirror[t.row][t.col]) begin
          live_mirror[t.row][t.col] = 1'b1;
          live_count++;
        end
      end
      fce_pkg::KIND_GEN: begin
        // Neighbours are counted from the old grid before any cell changes.
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++) begin
            n = 0;
            if (i > 0) n += live_mirror[i-1][j];
            if (i + 1 < nr) n += live_mirror[i+1][j];
            if (j > 0) n += live_mirror[i][j-1];
            if (j + 1 < nc) n += live_mirror[i][j+1];
            nbr[i][j] = n;
          end
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++) begin
            if (nbr[i][j] == 1 || nbr[i][j] == 3) begin
              if (live_mirror[i][j]) begin
                if (age_mirror[i][j] < AGE_SAT) age_mirror[i][j]++;
              end else begin
                live_mirror[i][j] = 1'b1;
                live_count++;
              end
            end else if (live_mirror[i][j]) begin
              live_mirror[i][j] = 1'b0;
              live_count--;
            end
          end
      end
      fce_pkg::KIND_READ: begin
        if (in_area) begin
          r.alive = live_mirror[t.row][t.col];
          r.age   = age_mirror[t.row][t.col][7:0];
        end
      end
      default: begin
        foreach (live_mirror[i, j]) begin
          live_mirror[i][j] = 1'b0;
          age_mirror[i][j] = 0;
        end
        live_count = 0;
      end
    endcase
    r.population = live_count[fce_pkg::POP_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Sends one transaction after a random gap; the result is predicted on acceptance.
  task automatic send_transaction(fce_pkg::kind_t k, int r, int c);
    fce_pkg::in_t t;
    t.kind = k;
    t.row = r[5:0];
    t.col = c[5:0];
    repeat ($urandom_range(0, 4)) @(negedge clk);
    in_valid = 1'b1;
    in_data  = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.insert(expected_q.size(), predict_transaction(t));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drains outstanding results, lets the engine settle, then writes a register.
  task automatic write_register(logic [fce_pkg::IDX_W-1:0] index, int value);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[fce_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (index == fce_pkg::REG_GRID_ROWS) rows_reg = value[6:0];
    else cols_reg = value[6:0];
  endtask

  task automatic set_grid(int r, int c);
    write_register(fce_pkg::REG_GRID_ROWS, r);
    write_register(fce_pkg::REG_GRID_COLS, c);
  endtask

  // Directed checks: corners, out-of-area set and read, aging, clear.
  task automatic test_directed();
    set_grid(4, 5);
    send_transaction(fce_pkg::KIND_READ, 0, 0);
    send_transaction(fce_pkg::KIND_SET, 0, 0);
    send_transaction(fce_pkg::KIND_SET, 0, 0);        // set on a live cell changes nothing
    send_transaction(fce_pkg::KIND_SET, 3, 4);
    send_transaction(fce_pkg::KIND_SET, 63, 63);      // outside the active area
    send_transaction(fce_pkg::KIND_READ, 63, 63);
    send_transaction(fce_pkg::KIND_GEN, 63, 0);
    send_transaction(fce_pkg::KIND_READ, 0, 0);       // dead cell keeps its age
    send_transaction(fce_pkg::KIND_READ, 0, 1);
    send_transaction(fce_pkg::KIND_GEN, 0, 63);
    send_transaction(fce_pkg::KIND_READ, 0, 1);
    send_transaction(fce_pkg::KIND_CLEAR, 21, 42);
    send_transaction(fce_pkg::KIND_READ, 0, 1);
    // A lone pair on a one-row grid ages every generation.
    set_grid(1, 2);
    send_transaction(fce_pkg::KIND_SET, 0, 0);
    send_transaction(fce_pkg::KIND_SET, 0, 1);
    repeat (6) send_transaction(fce_pkg::KIND_GEN, 0, 0);
    send_transaction(fce_pkg::KIND_READ, 0, 0);
    send_transaction(fce_pkg::KIND_READ, 0, 1);
  endtask

  // Register extremes, including zero and values above the grid size.
  task automatic test_register_extremes();
    set_grid(0, 0);
    send_transaction(fce_pkg::KIND_SET, 0, 0);
    send_transaction(fce_pkg::KIND_GEN, 0, 0);
    send_transaction(fce_pkg::KIND_READ, 0, 0);
    set_grid(127, 127);
    send_transaction(fce_pkg::KIND_SET, 63, 63);
    send_transaction(fce_pkg::KIND_SET, 0, 63);
    send_transaction(fce_pkg::KIND_GEN, 0, 0);        // one full-size generation
    send_transaction(fce_pkg::KIND_READ, 63, 63);
    // Shrink after use: cells outside stay in the population but read as zero.
    set_grid(2, 2);
    send_transaction(fce_pkg::KIND_READ, 63, 63);
    send_transaction(fce_pkg::KIND_GEN, 0, 0);
    set_grid(64, 64);
    send_transaction(fce_pkg::KIND_READ, 63, 63);
    send_transaction(fce_pkg::KIND_CLEAR, 0, 0);
  endtask

  // Random traffic on small grids, mostly sets and reads near the active area.
  task automatic test_random(int count);
    int k, r, c;
    for (int n = 0; n < count; n++) begin
      if (n % 35 == 0) set_grid($urandom_range(1, 8), $urandom_range(1, 8));
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
      end else begin
        r = $urandom_range(0, 8);
        c = $urandom_range(0, 8);
      end
      if (k < 40) send_transaction(fce_pkg::KIND_SET, r, c);
      else if (k < 60) send_transaction(fce_pkg::KIND_GEN, r, c);
      else if (k < 97) send_transaction(fce_pkg::KIND_READ, r, c);
      else send_transaction(fce_pkg::KIND_CLEAR, r, c);
    end
  endtask

  // The receiver stalls for a long stretch while transactions keep coming.
  task automatic test_backpressure();
    set_grid(3, 3);
    hold_off_cycles = 300;
    for (int n = 0; n < 12; n++)
      send_transaction(fce_pkg::kind_t'($urandom_range(0, 2)), $urandom_range(0, 3),
                       $urandom_range(0, 3));
  endtask

  // Receiver: random stalls per transaction, plus the long hold-off.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else if (out_ready && out_valid) begin
        out_ready <= 1'b1;
      end else begin
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    fce_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.alive != want.alive)
          report_mismatch("alive", out_data.alive, want.alive);
        if (out_data.age != want.age) report_mismatch("age", out_data.age, want.age);
        if (out_data.population != want.population)
          report_mismatch("population", out_data.population, want.population);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fredkin_cell_automaton_engine regression: fail");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    live_count = 0;
    rows_reg = fce_pkg::CFG_RESET;
    cols_reg = fce_pkg::CFG_RESET;
    foreach (live_mirror[i, j]) begin
      live_mirror[i][j] = 1'b0;
      age_mirror[i][j] = 0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(93);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (error_count == 0 && expected_q.size() == 0)
      $display("fredkin_cell_automaton_engine regression: pass");
    else
      $display("fredkin_cell_automaton_engine regression: fail");
    $finish;
  end
endmodule
